@@ hdl/bss_pkg.sv @@
// ----------------------------------------------------------------------------
// bss_pkg
// Shared types and constants of the byte signature search block.
// ----------------------------------------------------------------------------
package bss_pkg;

  localparam int unsigned DATA_W    = 8;
  localparam int unsigned OFFSET_W  = 32;
  localparam int unsigned SIG_W     = 64;
  localparam int unsigned LEN_W     = 5;
  localparam int unsigned SIG_BYTES = 16;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIG_LOW  = 2'd0,
    REG_SIG_HIGH = 2'd1,
    REG_SIG_LEN  = 2'd2
  } bss_reg_e;

  typedef struct packed {
    logic [SIG_W-1:0] sig_low;
    logic [SIG_W-1:0] sig_high;
    logic [LEN_W-1:0] sig_len;
  } bss_cfg_t;

  typedef struct packed {
    logic [DATA_W-1:0] data_byte;
    logic              last;
  } bss_item_t;

  typedef struct packed {
    logic                found;
    logic [OFFSET_W-1:0] offset;
  } bss_result_t;

endpackage

@@ hdl/bss_if.sv @@
// ----------------------------------------------------------------------------
// bss_if
// Channel interfaces: byte stream in, search result out, register writes.
// ----------------------------------------------------------------------------
interface bss_in_if
  import bss_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;
  logic              last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface bss_out_if
  import bss_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                found;
  logic [OFFSET_W-1:0] offset;

  modport source (output valid, output found, output offset, input ready);
  modport sink   (input valid, input found, input offset, output ready);
endinterface

interface bss_cfg_if
  import bss_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [SIG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/bss_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// bss_cfg_regs
// Signature and length registers, written through the configuration channel.
// ----------------------------------------------------------------------------
module bss_cfg_regs
  import bss_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  bss_cfg_if.sink       cfg_i,
  output bss_cfg_t      cfg_o
);

  bss_cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_i.valid) begin
      case (bss_reg_e'(cfg_i.index))
        REG_SIG_LOW: begin
          cfg_q.sig_low <= cfg_i.data;
        end
        REG_SIG_HIGH: begin
          cfg_q.sig_high <= cfg_i.data;
        end
        REG_SIG_LEN: begin
          cfg_q.sig_len <= cfg_i.data[LEN_W-1:0];
        end
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

endmodule

@@ hdl/bss_in_reg.sv @@
// ----------------------------------------------------------------------------
// bss_in_reg
// Input register: holds one accepted byte until the scan stage takes it.
// ----------------------------------------------------------------------------
module bss_in_reg
  import bss_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  bss_in_if.sink    in_i,
  output bss_item_t item_o,
  output logic      item_valid_o,
  input  logic      take_i
);

  bss_item_t item_q;
  logic      valid_q;

  assign in_i.ready   = !valid_q || take_i;
  assign item_o       = item_q;
  assign item_valid_o = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q.data_byte <= in_i.data_byte;
      item_q.last      <= in_i.last;
    end
  end

endmodule

@@ hdl/bss_scan.sv @@
// ----------------------------------------------------------------------------
// bss_scan
// Byte window, position count, parallel signature compare and result register.
// ----------------------------------------------------------------------------
module bss_scan
  import bss_pkg::*;
#(
  parameter int unsigned MAX_SIGNATURE = 16,
  parameter int unsigned POSITION_BITS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  bss_cfg_t  cfg_i,
  input  bss_item_t item_i,
  input  logic      item_valid_i,
  output logic      take_o,
  bss_out_if.source out_o
);

  localparam int unsigned IDX_W = (MAX_SIGNATURE > 1) ? $clog2(MAX_SIGNATURE) : 1;
  localparam int unsigned EXT_W = (POSITION_BITS > OFFSET_W) ? POSITION_BITS : OFFSET_W;

  logic [DATA_W-1:0]        win_q [MAX_SIGNATURE];
  logic [DATA_W-1:0]        win_d [MAX_SIGNATURE];
  logic [POSITION_BITS-1:0] pos_q;
  logic [POSITION_BITS-1:0] pos_d;
  logic                     reported_q;
  logic                     out_valid_q;
  bss_result_t              res_q;

  logic [2*SIG_W-1:0]       sig_all;
  logic [MAX_SIGNATURE-1:0] eq;
  logic [LEN_W-1:0]         idx;
  logic                     len_ok;
  logic                     pos_ok;
  logic                     hit;
  logic                     produce;
  logic [POSITION_BITS-1:0] start;
  logic [EXT_W-1:0]         start_ext;
  bss_result_t              res_d;

  assign take_o    = item_valid_i && (!out_valid_q || out_o.ready);
  assign sig_all   = {cfg_i.sig_high, cfg_i.sig_low};

  always_comb begin
    win_d[0] = item_i.data_byte;
    for (int unsigned i = 1; i < MAX_SIGNATURE; i++) begin
      win_d[i] = win_q[i-1];
    end
    pos_d = (pos_q == {POSITION_BITS{1'b1}}) ? pos_q : pos_q + 1'b1;
  end

  always_comb begin
    idx = '0;
    for (int unsigned j = 0; j < MAX_SIGNATURE; j++) begin
      idx   = cfg_i.sig_len - LEN_W'(j) - LEN_W'(1);
      eq[j] = (LEN_W'(j) >= cfg_i.sig_len) ||
              (win_d[idx[IDX_W-1:0]] == sig_all[8*j +: 8]);
    end
  end

  assign len_ok    = (cfg_i.sig_len != '0) && (cfg_i.sig_len <= LEN_W'(MAX_SIGNATURE));
  assign pos_ok    = pos_d >= POSITION_BITS'(cfg_i.sig_len);
  assign hit       = len_ok && pos_ok && (&eq);
  assign produce   = !reported_q && (hit || item_i.last);
  assign start     = pos_d - POSITION_BITS'(cfg_i.sig_len);
  assign start_ext = EXT_W'(start);

  always_comb begin
    res_d.found  = hit;
    res_d.offset = '0;
    if (hit) begin
      if (start_ext > EXT_W'({OFFSET_W{1'b1}})) begin
        res_d.offset = '1;
      end else begin
        res_d.offset = start_ext[OFFSET_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned i = 0; i < MAX_SIGNATURE; i++) begin
        win_q[i] <= '0;
      end
      pos_q      <= '0;
      reported_q <= 1'b0;
    end else if (take_o) begin
      if (item_i.last) begin
        for (int unsigned i = 0; i < MAX_SIGNATURE; i++) begin
          win_q[i] <= '0;
        end
        pos_q      <= '0;
        reported_q <= 1'b0;
      end else if (!reported_q) begin
        win_q      <= win_d;
        pos_q      <= pos_d;
        reported_q <= hit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take_o && produce) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && produce) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.found  = res_q.found;
  assign out_o.offset = res_q.offset;

  a_nomatch_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_q.found) |-> (res_q.offset == '0))
    else $error("no-match result with nonzero offset");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_o && item_i.last) |=> ((pos_q == '0) && !reported_q))
    else $error("scan state not cleared after final byte");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_o && reported_q) |-> !produce)
    else $error("second result in one scan");

  a_hit_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_o && produce && hit && !item_i.last) |=> reported_q)
    else $error("match not recorded");

endmodule

@@ hdl/byte_signature_search.sv @@
// ----------------------------------------------------------------------------
// byte_signature_search
// Finds the first occurrence of a configured byte signature in a stream.
// ----------------------------------------------------------------------------
// Usage: write signature_low, signature_high and signature_length over cfg_i
// while no scan is in flight; every write transfers at once. Stream the
// buffer over in_i one byte per transfer, with last set on the final byte.
// out_o carries one transfer per scan: found set with the start offset of the
// first match, or found clear with offset zero once the final byte passes
// without a match. Bytes after a match produce nothing; the final byte closes
// the scan and the next byte starts a new one at offset zero.
// Throughput is one byte per cycle while out_o is not stalled; the signature
// compare is a combinational, parallel check of the whole window.
// A result passes the input register and then the result register before it
// shows on out_o, and the result register must be free to take a new one.
// When out_o stalls, the held result blocks the scan stage and the input
// register fills; in_i ready then drops until the result transfers.
// Reset clears the signature, the window, the position count and both
// valid flags; no clearing pass is needed.
// ----------------------------------------------------------------------------
module byte_signature_search
  import bss_pkg::*;
#(
  parameter int unsigned MAX_SIGNATURE = 16,
  parameter int unsigned POSITION_BITS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bss_cfg_if.sink   cfg_i,
  bss_in_if.sink    in_i,
  bss_out_if.source out_o
);

  bss_cfg_t  cfg;
  bss_item_t item;
  logic      item_valid;
  logic      take;

  bss_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  bss_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .item_o       (item),
    .item_valid_o (item_valid),
    .take_i       (take)
  );

  bss_scan #(
    .MAX_SIGNATURE (MAX_SIGNATURE),
    .POSITION_BITS (POSITION_BITS)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_i       (item),
    .item_valid_i (item_valid),
    .take_o       (take),
    .out_o        (out_o)
  );

endmodule

@@ test/byte_signature_search_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_signature_search_test
// Self-checking bench for the byte signature search block. A cycle-free model
// tracks the byte window, position count and match flag, and predicts the
// verdict of each scan. Directed scans cover the corner cases. Random scans
// with planted, broken and absent signatures then run under several
// idle/stall mixes and one long output hold-off. Every result is compared
// against the oldest predicted verdict.
// ----------------------------------------------------------------------------
module byte_signature_search_test;
  import bss_pkg::*;

  localparam int unsigned HALF_PERIOD    = 4;
  localparam int unsigned RESET_CYCLES   = 7;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned WATCHDOG_LIMIT = 5000;

  logic clk_i = 1'b0;
  logic rst_ni;

  bss_cfg_if cfg_if ();
  bss_in_if  in_if ();
  bss_out_if out_if ();

  byte_signature_search DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // Search model state
  logic [2*SIG_W-1:0]  signature;
  logic [LEN_W-1:0]    sig_len;
  logic [DATA_W-1:0]   window_bytes [SIG_BYTES];
  logic [OFFSET_W-1:0] byte_count;
  logic                match_done;
  bss_result_t         search_verdicts [$];

  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;
  int unsigned bytes_sent;
  int unsigned errors;
  int unsigned hold_requests;
  int unsigned hold_ack;
  int unsigned hold_left;
  int unsigned quiet_cycles;
  logic [DATA_W-1:0] alpha_lo;
  logic [DATA_W-1:0] alpha_hi;
  bss_result_t       want;

  function automatic void clear_scan();
    foreach (window_bytes[i]) window_bytes[i] = '0;
    byte_count = '0;
    match_done = 1'b0;
  endfunction

  function automatic void track_byte(input logic [DATA_W-1:0] b, input logic l);
    bss_result_t verdict;
    logic        hit;
    if (!match_done) begin
      for (int i = SIG_BYTES - 1; i > 0; i--) window_bytes[i] = window_bytes[i-1];
      window_bytes[0] = b;
      if (byte_count != '1) byte_count++;
      hit = (sig_len != 0) && (sig_len <= SIG_BYTES) && (byte_count >= sig_len);
      for (int j = 0; j < SIG_BYTES; j++) begin
        if (hit && j < sig_len && window_bytes[sig_len-1-j] != signature[8*j +: 8]) hit = 1'b0;
      end
      if (hit) begin
        verdict.found  = 1'b1;
        verdict.offset = byte_count - sig_len;
        match_done     = 1'b1;
        search_verdicts.push_back(verdict);
      end else if (l) begin
        verdict.found  = 1'b0;
        verdict.offset = '0;
        search_verdicts.push_back(verdict);
      end
    end
    if (l) clear_scan();
  endfunction

  function automatic logic [DATA_W-1:0] pick_byte(input bit narrow);
    if (narrow) return $urandom_range(1) ? alpha_hi : alpha_lo;
    return DATA_W'($urandom_range(255));
  endfunction

  // Result side: check each transfer, then drive ready
  always @(posedge clk_i) begin
    if (out_if.valid && out_if.ready) begin
      if (search_verdicts.size() == 0) begin
        $display("%0t: unexpected result found=%0b offset=%0d", $time,
                 out_if.found, out_if.offset);
        errors++;
      end else begin
        want = search_verdicts.pop_front();
        if (out_if.found !== want.found) begin
          $display("%0t: found mismatch, expected %0b actual %0b", $time,
                   want.found, out_if.found);
          errors++;
        end
        if (out_if.offset !== want.offset) begin
          $display("%0t: offset mismatch, expected %0d actual %0d", $time,
                   want.offset, out_if.offset);
          errors++;
        end
      end
    end
    if (hold_requests != hold_ack) begin
      hold_ack     <= hold_requests;
      hold_left    <= HOLD_CYCLES;
      out_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input bss_reg_e idx, input logic [SIG_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      REG_SIG_LOW:  signature[SIG_W-1:0]       = value;
      REG_SIG_HIGH: signature[2*SIG_W-1:SIG_W] = value;
      REG_SIG_LEN:  sig_len                    = value[LEN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_signature(input logic [SIG_W-1:0] lo, input logic [SIG_W-1:0] hi,
                                   input logic [LEN_W-1:0] len);
    write_reg(REG_SIG_LOW, lo);
    write_reg(REG_SIG_HIGH, hi);
    write_reg(REG_SIG_LEN, SIG_W'(len));
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_byte(input logic [DATA_W-1:0] b, input logic l);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.data_byte <= b;
    in_if.last      <= l;
    do @(posedge clk_i); while (!in_if.ready);
    track_byte(b, l);
    bytes_sent++;
  endtask

  // Drop valid, wait out every verdict and any bytes still in flight
  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (search_verdicts.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_scan(input bit narrow, input int unsigned max_len);
    logic [DATA_W-1:0] stream [$];
    int unsigned       n;
    int unsigned       at;
    int unsigned       plants;
    n = ($urandom_range(9) == 0) ? $urandom_range(2 * max_len, max_len + 1)
                                 : $urandom_range(max_len, 1);
    for (int i = 0; i < n; i++) stream.push_back(pick_byte(narrow));
    plants = $urandom_range(2);
    if (sig_len != 0 && sig_len <= SIG_BYTES) begin
      for (int p = 0; p < plants; p++) begin
        at = $urandom_range(n - 1);
        for (int k = 0; k < sig_len && at + k < n; k++) stream[at+k] = signature[8*k +: 8];
        if ($urandom_range(3) == 0) stream[at] = ~stream[at];
      end
    end
    foreach (stream[i]) send_byte(stream[i], i == stream.size() - 1);
  endtask

  task automatic program_random_signature(output bit narrow);
    logic [2*SIG_W-1:0] sig;
    logic [LEN_W-1:0]   len;
    int unsigned        pick;
    narrow   = $urandom_range(1);
    alpha_lo = DATA_W'($urandom_range(255));
    alpha_hi = DATA_W'($urandom_range(255));
    for (int i = 0; i < SIG_BYTES; i++) sig[8*i +: 8] = pick_byte(narrow);
    pick = $urandom_range(19);
    if (pick == 0)      len = '0;
    else if (pick == 1) len = LEN_W'($urandom_range(31, SIG_BYTES + 1));
    else if (pick == 2) len = LEN_W'(SIG_BYTES);
    else                len = LEN_W'($urandom_range(SIG_BYTES, 1));
    program_signature(sig[SIG_W-1:0], sig[2*SIG_W-1:SIG_W], len);
  endtask

  task automatic test_directed();
    src_idle_pct = 0;
    // zero length from reset: never matches
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    settle();
    // overlong length: never matches
    program_signature('1, '1, 5'd31);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    settle();
    // short stream, then a match followed by ignored bytes
    program_signature('0, '0, 5'd2);
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    settle();
    // full-length signature matching on the final byte
    program_signature(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, LEN_W'(SIG_BYTES));
    for (int j = 0; j < SIG_BYTES; j++) send_byte(signature[8*j +: 8], j == SIG_BYTES - 1);
    settle();
  endtask

  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
                                     input int unsigned items);
    int unsigned start;
    bit          narrow;
    start          = bytes_sent;
    src_idle_pct   = idle_pct;
    sink_stall_pct <= stall_pct;
    while (bytes_sent - start < items) begin
      program_random_signature(narrow);
      repeat ($urandom_range(5, 3)) send_scan(narrow, 24);
      settle();
    end
  endtask

  task automatic test_backpressure();
    bit narrow;
    src_idle_pct   = 0;
    sink_stall_pct <= 0;
    program_random_signature(narrow);
    program_signature(signature[SIG_W-1:0], signature[2*SIG_W-1:SIG_W], 5'd2);
    hold_requests <= hold_requests + 1;
    repeat (12) send_scan(narrow, 3);
    settle();
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = REG_SIG_LOW;
    cfg_if.data     = '0;
    in_if.valid     = 1'b0;
    in_if.data_byte = '0;
    in_if.last      = 1'b0;
    out_if.ready    = 1'b0;
    signature       = '0;
    sig_len         = '0;
    src_idle_pct    = 0;
    sink_stall_pct  = 0;
    bytes_sent      = 0;
    errors          = 0;
    hold_requests   = 0;
    hold_ack        = 0;
    hold_left       = 0;
    quiet_cycles    = 0;
    alpha_lo        = '0;
    alpha_hi        = '1;
    clear_scan();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_traffic(0, 0, 80);
    test_random_traffic(78, 0, 70);
    test_random_traffic(0, 78, 70);
    test_random_traffic(9, 9, 70);
    test_backpressure();

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/bss_pkg.sv
hdl/bss_if.sv
hdl/bss_cfg_regs.sv
hdl/bss_in_reg.sv
hdl/bss_scan.sv
hdl/byte_signature_search.sv
test/byte_signature_search_test.sv
